FILE: src/iale_pkg.sv
// shared types and constants of the indexed array list engine
package iale_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4,
    OP_FIND   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_RANGE   = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_MISSING = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_FETCH,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [ADDR_W-1:0]        found_position;
    status_e                  status;
    logic [CNT_W-1:0]         count;
  } out_item_t;

endpackage

FILE: src/indexed_array_list_engine_core.sv
// ordered list of signed words held in one single-port-write, registered-read memory
//
// An ordered list of up to 256 signed 32-bit words kept in a memory with one
// write port and one read port whose read data is registered. One item is
// worked on at a time; the input stalls until its result has been staged.
// Push, pop, read, error cases and unused op codes need no pass over the
// list; pop and read go through a single memory read. Insert at position p
// below the end moves the entries from p to the last one place higher, delete
// moves those above p one place lower, and find examines entries from 0 up to
// the first match (or all of them when nothing matches): the memory moves or
// examines one entry per cycle, which sets how long these three take. The
// result register lets the next item be accepted while a result still waits
// to be taken. The memory contents need no clearing after reset.
module indexed_array_list_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iale_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iale_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = iale_pkg::ADDR_W;
  localparam int unsigned CW = iale_pkg::CNT_W;
  localparam int unsigned DW = iale_pkg::DATA_W;

  // list storage
  logic [DW-1:0] mem_q [iale_pkg::DEPTH];
  logic [DW-1:0] rdata_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;

  iale_pkg::state_e    state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [DW-1:0]       val_q, val_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       paddr_q, paddr_d;
  logic                pend_q, pend_d;
  logic                more_q, more_d;
  iale_pkg::out_item_t res_q, res_d;
  iale_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic          accept, full, empty, out_free;
  logic [CW-1:0] cnt_m1, cnt_p1;
  logic [AW-1:0] last_addr;

  // count widened to the position field for range checks
  function automatic logic [iale_pkg::POS_W-1:0] POS_EXT(input logic [CW-1:0] c);
    POS_EXT = iale_pkg::POS_W'(c);
  endfunction

  assign accept    = in_valid_i && (state_q == iale_pkg::ST_IDLE);
  assign full      = (count_q == CW'(iale_pkg::DEPTH));
  assign empty     = (count_q == '0);
  assign cnt_m1    = count_q - 1'b1;
  assign cnt_p1    = count_q + 1'b1;
  assign last_addr = cnt_m1[AW-1:0];
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != iale_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    paddr_d     = paddr_q;
    pend_d      = pend_q;
    more_d      = more_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (state_q)
      iale_pkg::ST_IDLE: begin
        if (accept) begin
          res_d.data           = '0;
          res_d.found_position = '0;
          res_d.status         = iale_pkg::STAT_OK;
          res_d.count          = count_q;
          pos_d                = in_item_i.position[AW-1:0];
          val_d                = in_item_i.value;
          pend_d               = 1'b0;
          more_d               = 1'b1;
          state_d              = iale_pkg::ST_RESULT;
          unique case (in_item_i.op)
            iale_pkg::OP_PUSH: begin
              if (full) begin
                res_d.status = iale_pkg::STAT_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = count_q[AW-1:0];
                mem_wdata   = in_item_i.value;
                count_d     = cnt_p1;
                res_d.count = cnt_p1;
              end
            end
            iale_pkg::OP_INSERT: begin
              if (full) begin
                res_d.status = iale_pkg::STAT_FULL;
              end else if (in_item_i.position > POS_EXT(count_q)) begin
                res_d.status = iale_pkg::STAT_RANGE;
              end else if (in_item_i.position == POS_EXT(count_q)) begin
                // insert at the end is an append
                mem_we      = 1'b1;
                mem_waddr   = count_q[AW-1:0];
                mem_wdata   = in_item_i.value;
                count_d     = cnt_p1;
                res_d.count = cnt_p1;
              end else begin
                ptr_d   = last_addr;
                state_d = iale_pkg::ST_SHIFT_UP;
              end
            end
            iale_pkg::OP_POP: begin
              if (empty) begin
                res_d.status = iale_pkg::STAT_EMPTY;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = last_addr;
                count_d     = cnt_m1;
                res_d.count = cnt_m1;
                state_d     = iale_pkg::ST_FETCH;
              end
            end
            iale_pkg::OP_DELETE: begin
              if (in_item_i.position >= POS_EXT(count_q)) begin
                res_d.status = iale_pkg::STAT_RANGE;
              end else if (in_item_i.position == POS_EXT(cnt_m1)) begin
                // last entry goes without moving anything
                count_d     = cnt_m1;
                res_d.count = cnt_m1;
              end else begin
                ptr_d   = in_item_i.position[AW-1:0] + 1'b1;
                state_d = iale_pkg::ST_SHIFT_DN;
              end
            end
            iale_pkg::OP_READ: begin
              if (in_item_i.position >= POS_EXT(count_q)) begin
                res_d.status = iale_pkg::STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_item_i.position[AW-1:0];
                state_d   = iale_pkg::ST_FETCH;
              end
            end
            iale_pkg::OP_FIND: begin
              if (empty) begin
                res_d.status = iale_pkg::STAT_MISSING;
              end else begin
                ptr_d   = '0;
                state_d = iale_pkg::ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // read downward from the last entry, write each word one place higher
      iale_pkg::ST_SHIFT_UP: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_q + 1'b1;
          mem_wdata = rdata_q;
        end
        if (more_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          pend_d    = 1'b1;
          paddr_d   = ptr_q;
          if (ptr_q == pos_q) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q - 1'b1;
          end
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = pos_q;
          mem_wdata   = val_q;
          count_d     = cnt_p1;
          res_d.count = cnt_p1;
          state_d     = iale_pkg::ST_RESULT;
        end
      end

      // read upward past the removed entry, write each word one place lower
      iale_pkg::ST_SHIFT_DN: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_q - 1'b1;
          mem_wdata = rdata_q;
        end
        if (more_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          pend_d    = 1'b1;
          paddr_d   = ptr_q;
          if (ptr_q == last_addr) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          count_d     = cnt_m1;
          res_d.count = cnt_m1;
          state_d     = iale_pkg::ST_RESULT;
        end
      end

      iale_pkg::ST_FETCH: begin
        res_d.data = rdata_q;
        state_d    = iale_pkg::ST_RESULT;
      end

      // compare the word read last cycle while the next one is fetched
      iale_pkg::ST_SEARCH: begin
        if (pend_q && (rdata_q == val_q)) begin
          res_d.found_position = paddr_q;
          res_d.status         = iale_pkg::STAT_OK;
          state_d              = iale_pkg::ST_RESULT;
        end else if (more_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          pend_d    = 1'b1;
          paddr_d   = ptr_q;
          if (ptr_q == last_addr) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          res_d.status = iale_pkg::STAT_MISSING;
          state_d      = iale_pkg::ST_RESULT;
        end
      end

      iale_pkg::ST_RESULT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = iale_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = iale_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iale_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      more_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      more_q      <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    val_q   <= val_d;
    ptr_q   <= ptr_d;
    paddr_q <= paddr_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule
